>>> hw/rtl/csmacd_pkg.sv
// Package for the CSMA/CD station transmitter: item types, config type,
// phase codes and reset values. No dependencies.
`timescale 1ns / 1ps

package csmacd_pkg;

	// Field widths
	localparam int TICKS_W   = 10;
	localparam int CAP_W     = 4;
	localparam int FLEN_W    = 12;
	localparam int SLOTS_W   = 10;
	localparam int COUNT_W   = 8;
	localparam int CD_W      = 20;
	localparam int PHASE_W   = 3;
	localparam int CFG_IDX_W = 2;

	// Backoff exponent never exceeds this
	localparam int BACKOFF_BITS = 10;

	// Default width of the saturating collision counter
	localparam int COLLISION_COUNT_BITS_DEF = 8;

	// Register reset values
	localparam logic [TICKS_W-1:0] SLOT_TICKS_RST   = 10'd40;
	localparam logic [TICKS_W-1:0] SENSE_RETRY_RST  = 10'd30;
	localparam logic [TICKS_W-1:0] DETECT_WIN_RST   = 10'd20;
	localparam logic [CAP_W-1:0]   BACKOFF_CAP_RST  = 4'd10;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENSE_RETRY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_WIN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_CAP = 2'd3;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE    = 3'd0,
		PH_DEFER   = 3'd1,
		PH_DETECT  = 3'd2,
		PH_BODY    = 3'd3,
		PH_BACKOFF = 3'd4
	} phase_t;

	typedef struct packed {
		logic               frame_request;
		logic [FLEN_W-1:0]  frame_ticks;
		logic               channel_busy;
		logic               collision;
		logic [SLOTS_W-1:0] random_value;
	} in_item_t;

	typedef struct packed {
		logic               transmitting;
		logic               jam;
		logic               frame_sent;
		logic [SLOTS_W-1:0] backoff_slots;
		logic [COUNT_W-1:0] coll_count;
		logic [PHASE_W-1:0] phase;
	} out_item_t;

	typedef struct packed {
		logic [TICKS_W-1:0] slot_ticks;
		logic [TICKS_W-1:0] sense_retry_ticks;
		logic [TICKS_W-1:0] detect_window_ticks;
		logic [CAP_W-1:0]   backoff_cap;
	} cfg_t;

endpackage

>>> hw/rtl/csmacd_core.sv
// Next-state logic for one tick of the transmit controller: phase sequencing,
// countdowns, collision counting and backoff slot choice. Uses csmacd_pkg.
`timescale 1ns / 1ps

module csmacd_core #(
	parameter int COLLISION_COUNT_BITS = csmacd_pkg::COLLISION_COUNT_BITS_DEF
) (
	input  csmacd_pkg::cfg_t                         cfg,
	input  csmacd_pkg::in_item_t                     item,
	input  csmacd_pkg::phase_t                       phase_cur,
	input  logic [csmacd_pkg::CD_W-1:0]              cd_cur,
	input  logic [COLLISION_COUNT_BITS-1:0]          held_cur,
	input  logic [csmacd_pkg::FLEN_W-1:0]            body_cur,
	input  logic [csmacd_pkg::SLOTS_W-1:0]           slots_cur,
	output csmacd_pkg::phase_t                       phase_nxt,
	output logic [csmacd_pkg::CD_W-1:0]              cd_nxt,
	output logic [COLLISION_COUNT_BITS-1:0]          held_nxt,
	output logic [csmacd_pkg::FLEN_W-1:0]            body_nxt,
	output logic [csmacd_pkg::SLOTS_W-1:0]           slots_nxt,
	output csmacd_pkg::out_item_t                    result
);
	import csmacd_pkg::*;

	localparam logic [COLLISION_COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [CAP_W:0] EXP_LIM = (CAP_W+1)'(BACKOFF_BITS);

	logic [COLLISION_COUNT_BITS-1:0] held_inc;
	logic [CAP_W-1:0]                k_raw;
	logic [CAP_W:0]                  k_exp;
	logic [SLOTS_W-1:0]              mask;
	logic [SLOTS_W-1:0]              slots_new;
	logic [CD_W-1:0]                 span;
	logic [CD_W-1:0]                 cd_dec;
	logic [CD_W-1:0]                 retry_cd;
	logic                            cd_gt1;
	logic                            jam;
	logic                            sent;

	// Saturating collision count after this collision
	assign held_inc = (held_cur == CNT_MAX) ? held_cur : held_cur + 1'b1;

	// Backoff exponent: count limited by cap, then by BACKOFF_BITS
	assign k_raw = (held_inc < COLLISION_COUNT_BITS'(cfg.backoff_cap)) ?
		held_inc[CAP_W-1:0] : cfg.backoff_cap;
	assign k_exp = ({1'b0, k_raw} > EXP_LIM) ? EXP_LIM : {1'b0, k_raw};

	// Build the low-bit mask 2^k - 1
	always_comb begin
		for (int i = 0; i < SLOTS_W; i++) begin
			mask[i] = (k_exp > (CAP_W+1)'(i));
		end
	end

	assign slots_new = item.random_value & mask;
	assign span      = CD_W'(slots_new) * CD_W'(cfg.slot_ticks);
	assign cd_dec    = cd_cur - 1'b1;
	assign cd_gt1    = (cd_cur > CD_W'(1));
	assign retry_cd  = (cfg.sense_retry_ticks != '0) ?
		CD_W'(cfg.sense_retry_ticks - 1'b1) : '0;

	// Advance the phase sequencer by one tick
	always_comb begin
		phase_nxt = phase_cur;
		cd_nxt    = cd_cur;
		held_nxt  = held_cur;
		body_nxt  = body_cur;
		slots_nxt = slots_cur;
		jam       = 1'b0;
		sent      = 1'b0;
		case (phase_cur)
			PH_IDLE: begin
				if (item.frame_request) begin
					body_nxt  = item.frame_ticks;
					held_nxt  = '0;
					cd_nxt    = '0;
					phase_nxt = PH_DEFER;
				end
			end
			PH_DEFER: begin
				if (cd_cur != '0) begin
					cd_nxt = cd_dec;
				end else if (item.channel_busy) begin
					cd_nxt = retry_cd;
				end else begin
					cd_nxt    = CD_W'(cfg.detect_window_ticks);
					phase_nxt = PH_DETECT;
				end
			end
			PH_DETECT: begin
				if (cd_gt1) begin
					cd_nxt = cd_dec;
				end else if (item.collision) begin
					jam       = 1'b1;
					held_nxt  = held_inc;
					slots_nxt = slots_new;
					cd_nxt    = span;
					phase_nxt = (span != '0) ? PH_BACKOFF : PH_DEFER;
				end else begin
					cd_nxt    = CD_W'(body_cur);
					phase_nxt = PH_BODY;
				end
			end
			PH_BODY: begin
				if (cd_gt1) begin
					cd_nxt = cd_dec;
				end else begin
					sent      = 1'b1;
					held_nxt  = '0;
					cd_nxt    = '0;
					phase_nxt = PH_IDLE;
				end
			end
			PH_BACKOFF: begin
				if (cd_gt1) begin
					cd_nxt = cd_dec;
				end else begin
					cd_nxt    = '0;
					phase_nxt = PH_DEFER;
				end
			end
			default: begin
				cd_nxt    = '0;
				phase_nxt = PH_IDLE;
			end
		endcase
	end

	// Result item describes the state after this tick
	always_comb begin
		result.transmitting  = phase_nxt inside {PH_DETECT, PH_BODY};
		result.jam           = jam;
		result.frame_sent    = sent;
		result.backoff_slots = slots_nxt;
		result.coll_count    = COUNT_W'(held_nxt);
		result.phase         = PHASE_W'(phase_nxt);
	end

endmodule

>>> hw/rtl/csma_cd_station_transmitter_top.sv
// CSMA/CD station transmit controller, one tick per input item.
// Depends on csmacd_pkg and csmacd_core.
//
// Usage:
//   Each input item on in_valid/in_stall/in_data is one time tick of the
//   MAC: a frame request with its body length, the sensed carrier, the
//   collision flag and random bits for the backoff choice. Every accepted
//   tick yields exactly one result item on out_valid/out_stall/out_data
//   with the transmit, jam and frame_sent flags, chosen backoff slots,
//   collision count and phase after that tick.
//   The result is registered: it is in the output register the cycle
//   after the tick is accepted. Throughput is one tick per cycle; the path
//   through the next-state logic, with its 10x10 slot multiply, fits in
//   that cycle.
//   While a result waits under out_stall, in_stall is raised and the
//   tick and controller state hold; once the result is taken a new tick
//   is accepted in the same cycle.
//   Reset puts the controller in idle with zero counts and loads the
//   default slot, retry, detect window and cap registers. The user writes
//   registers via cfg_we/cfg_index/cfg_data while no tick is in flight (not enforced).
`timescale 1ns / 1ps

module csma_cd_station_transmitter_top #(
	parameter int COLLISION_COUNT_BITS = csmacd_pkg::COLLISION_COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [csmacd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [csmacd_pkg::TICKS_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  csmacd_pkg::in_item_t                in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output csmacd_pkg::out_item_t               out_data
);
	import csmacd_pkg::*;

	cfg_t                            cfg_q;
	phase_t                          phase_q;
	logic [CD_W-1:0]                 cd_q;
	logic [COLLISION_COUNT_BITS-1:0] held_q;
	logic [FLEN_W-1:0]               body_q;
	logic [SLOTS_W-1:0]              slots_q;
	logic                            out_valid_q;
	out_item_t                       out_data_q;

	phase_t                          phase_d;
	logic [CD_W-1:0]                 cd_d;
	logic [COLLISION_COUNT_BITS-1:0] held_d;
	logic [FLEN_W-1:0]               body_d;
	logic [SLOTS_W-1:0]              slots_d;
	out_item_t                       result;
	logic                            accept;

	// Hold the input while a finished result is stalled
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_ticks          <= SLOT_TICKS_RST;
			cfg_q.sense_retry_ticks   <= SENSE_RETRY_RST;
			cfg_q.detect_window_ticks <= DETECT_WIN_RST;
			cfg_q.backoff_cap         <= BACKOFF_CAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOT_TICKS:  cfg_q.slot_ticks          <= cfg_data;
				REG_SENSE_RETRY: cfg_q.sense_retry_ticks   <= cfg_data;
				REG_DETECT_WIN:  cfg_q.detect_window_ticks <= cfg_data;
				REG_BACKOFF_CAP: cfg_q.backoff_cap         <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	csmacd_core #(
		.COLLISION_COUNT_BITS(COLLISION_COUNT_BITS)
	) u_core (
		.cfg       (cfg_q),
		.item      (in_data),
		.phase_cur (phase_q),
		.cd_cur    (cd_q),
		.held_cur  (held_q),
		.body_cur  (body_q),
		.slots_cur (slots_q),
		.phase_nxt (phase_d),
		.cd_nxt    (cd_d),
		.held_nxt  (held_d),
		.body_nxt  (body_d),
		.slots_nxt (slots_d),
		.result    (result)
	);

	// Advance controller state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cd_q    <= '0;
			held_q  <= '0;
			body_q  <= '0;
			slots_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cd_q    <= cd_d;
			held_q  <= held_d;
			body_q  <= body_d;
			slots_q <= slots_d;
		end
	end

	// Load the result register, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

	// Every accepted tick leaves a result behind it
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");

	// Jam and frame completion never share a tick
	a_jam_sent_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q.jam && out_data_q.frame_sent))
		else $error("jam and frame_sent in one result");

	// A finished frame returns to idle with a cleared count
	a_sent_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.frame_sent) |->
			(out_data_q.phase == PHASE_W'(PH_IDLE) && out_data_q.coll_count == '0))
		else $error("frame_sent without idle and cleared count");

	// A jam leads to backoff or defer and never leaves the station transmitting
	a_jam_backoff: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.jam) |->
			((out_data_q.phase == PHASE_W'(PH_BACKOFF) ||
			  out_data_q.phase == PHASE_W'(PH_DEFER)) && !out_data_q.transmitting))
		else $error("jam result in wrong phase");

endmodule
